// ===== hdl/tlsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsm_pkg: shared types and constants for the track lock state machine
// Mode encoding, result codes, register indexes and the per-beat item
// handed from the input stage to the state update stage.
// ----------------------------------------------------------------------------
package tlsm_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_LOCK_SCORE      = 3'd0;
    localparam logic [2:0] CFG_CONFIRM_FRAMES  = 3'd1;
    localparam logic [2:0] CFG_LOST_LIMIT      = 3'd2;
    localparam logic [2:0] CFG_HOLD_TIMEOUT_MS = 3'd3;
    localparam logic [2:0] CFG_FLOATING_GAP_MM = 3'd4;

    localparam int CfgDataW = 20;

    // reset values of the configuration registers
    localparam logic [10:0] LockScoreRst     = 11'd717;
    localparam logic [7:0]  ConfirmFramesRst = 8'd2;
    localparam logic [7:0]  MaxLostFramesRst = 8'd8;
    localparam logic [19:0] HoldTimeoutRst   = 20'd5000;
    localparam logic [14:0] FloatingGapRst   = 15'd300;

    // speed limit of 100 mm/s, squared
    localparam logic [31:0] SpeedSqLimit = 32'd10000;

    // load_state codes on the result port
    localparam logic [2:0] LOAD_UNKNOWN = 3'd0;
    localparam logic [2:0] LOAD_GROUND  = 3'd1;
    localparam logic [2:0] LOAD_MOVING  = 3'd2;
    localparam logic [2:0] LOAD_STATIC  = 3'd3;
    localparam logic [2:0] LOAD_LOST    = 3'd4;

    // risk codes
    localparam logic [1:0] RISK_IDLE    = 2'd0;
    localparam logic [1:0] RISK_NORMAL  = 2'd1;
    localparam logic [1:0] RISK_UNKNOWN = 2'd2;

    typedef enum logic [4:0] {
        MODE_UNKNOWN = 5'b00001,
        MODE_GROUND  = 5'b00010,
        MODE_MOVING  = 5'b00100,
        MODE_STATIC  = 5'b01000,
        MODE_LOST    = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [10:0] lock_score;
        logic [7:0]  confirm_frames;
        logic [7:0]  lost_limit;
        logic [19:0] hold_timeout_ms;
        logic [14:0] floating_gap_mm;
    } cfg_t;

    // one tracker report after the input register
    typedef struct packed {
        logic               valid;
        logic [15:0]        track;
        logic [10:0]        score;
        logic               fast;
        logic signed [15:0] clearance;
        logic [31:0]        stamp;
    } item_t;

    function automatic logic [2:0] load_code(mode_t m);
        logic [2:0] c;
        case (m)
            MODE_UNKNOWN: c = LOAD_UNKNOWN;
            MODE_GROUND:  c = LOAD_GROUND;
            MODE_MOVING:  c = LOAD_MOVING;
            MODE_STATIC:  c = LOAD_STATIC;
            MODE_LOST:    c = LOAD_LOST;
            default:      c = LOAD_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] risk_code(mode_t m);
        logic [1:0] r;
        case (m)
            MODE_UNKNOWN: r = RISK_UNKNOWN;
            MODE_LOST:    r = RISK_UNKNOWN;
            MODE_STATIC:  r = RISK_IDLE;
            MODE_GROUND:  r = RISK_NORMAL;
            MODE_MOVING:  r = RISK_NORMAL;
            default:      r = RISK_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/tlsm_cfg.sv =====
// ----------------------------------------------------------------------------
// tlsm_cfg: configuration register file
// Five write-only registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module tlsm_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [tlsm_pkg::CfgDataW-1:0] cfg_data,
    output tlsm_pkg::cfg_t                cfg
);
    import tlsm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOCK_SCORE:      cfg_next.lock_score      = cfg_data[10:0];
                CFG_CONFIRM_FRAMES:  cfg_next.confirm_frames  = cfg_data[7:0];
                CFG_LOST_LIMIT:      cfg_next.lost_limit      = cfg_data[7:0];
                CFG_HOLD_TIMEOUT_MS: cfg_next.hold_timeout_ms = cfg_data[19:0];
                CFG_FLOATING_GAP_MM: cfg_next.floating_gap_mm = cfg_data[14:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_score      <= LockScoreRst;
            cfg_reg.confirm_frames  <= ConfirmFramesRst;
            cfg_reg.lost_limit      <= MaxLostFramesRst;
            cfg_reg.hold_timeout_ms <= HoldTimeoutRst;
            cfg_reg.floating_gap_mm <= FloatingGapRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/tlsm_front.sv =====
// ----------------------------------------------------------------------------
// tlsm_front: input register
// Captures one report beat and reduces the velocity to a single
// over-speed flag (sum of squares against the limit).
// ----------------------------------------------------------------------------
module tlsm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                report_valid,
    input  logic [15:0]         report_track,
    input  logic [10:0]         report_score,
    input  logic signed [15:0]  vel_x,
    input  logic signed [15:0]  vel_y,
    input  logic signed [15:0]  vel_z,
    input  logic signed [15:0]  clearance_mm,
    input  logic [31:0]         stamp_ms,
    input  logic                take,
    output logic                item_valid,
    output tlsm_pkg::item_t     item
);
    import tlsm_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    item_t              item_reg;
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic signed [31:0] sq_z;
    logic [31:0]        speed_sq;
    logic               accept;

    // each square is at most 2^30, so the sum fits 32 bits unsigned
    assign sq_x     = vel_x * vel_x;
    assign sq_y     = vel_y * vel_y;
    assign sq_z     = vel_z * vel_z;
    assign speed_sq = 32'(sq_x) + 32'(sq_y) + 32'(sq_z);

    assign in_ready   = !valid_reg || take;
    assign accept     = in_valid && in_ready;
    assign valid_next = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.valid     <= report_valid;
            item_reg.track     <= report_track;
            item_reg.score     <= report_score;
            item_reg.fast      <= speed_sq > SpeedSqLimit;
            item_reg.clearance <= clearance_mm;
            item_reg.stamp     <= stamp_ms;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/tlsm_core.sv =====
// ----------------------------------------------------------------------------
// tlsm_core: lock state update and result register
// Applies one report to the lock state and registers the result beat.
// ----------------------------------------------------------------------------
module tlsm_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  tlsm_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  tlsm_pkg::item_t item,
    output logic            take,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      load_state,
    output logic            is_locked,
    output logic [15:0]     locked_track,
    output logic [1:0]      risk,
    output logic [7:0]      lost_frames
);
    import tlsm_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic        locked_reg;
    logic        locked_next;
    logic [15:0] locked_id_reg;
    logic [15:0] locked_id_next;
    logic [7:0]  miss_reg;
    logic [7:0]  miss_next;
    logic [7:0]  confirm_reg;
    logic [7:0]  confirm_next;
    logic [31:0] last_motion_reg;
    logic [31:0] last_motion_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  load_state_reg;
    logic        is_locked_reg;
    logic [15:0] locked_track_reg;
    logic [1:0]  risk_reg;
    logic [7:0]  lost_frames_reg;

    logic [7:0]  miss_inc;
    logic [7:0]  confirm_inc;
    logic [13:0] score_x5;
    logic [13:0] lock_x4;
    logic [31:0] since_motion;
    logic        in_hold;
    logic        suspended;

    assign take = item_valid && (!out_valid_reg || out_ready);

    assign miss_inc     = (miss_reg == 8'hFF) ? miss_reg : miss_reg + 8'd1;
    assign confirm_inc  = (confirm_reg == 8'hFF) ? confirm_reg : confirm_reg + 8'd1;
    // score >= 0.8 * lock_score, kept exact as 5*score >= 4*lock_score
    assign score_x5     = 14'({item.score, 2'b00}) + 14'(item.score);
    assign lock_x4      = 14'({cfg.lock_score, 2'b00});
    assign since_motion = item.stamp - last_motion_reg;
    assign in_hold      = since_motion < 32'(cfg.hold_timeout_ms);
    assign suspended    = item.clearance > $signed({1'b0, cfg.floating_gap_mm});

    always_comb
    begin
        mode_next        = mode_reg;
        locked_next      = locked_reg;
        locked_id_next   = locked_id_reg;
        miss_next        = miss_reg;
        confirm_next     = confirm_reg;
        last_motion_next = last_motion_reg;
        if (take)
        begin
            if (!item.valid)
            begin
                if (mode_reg == MODE_MOVING || mode_reg == MODE_STATIC)
                begin
                    miss_next = miss_inc;
                    if (miss_inc > cfg.lost_limit)
                    begin
                        mode_next      = MODE_LOST;
                        locked_next    = 1'b0;
                        locked_id_next = 16'd0;
                    end
                end
            end
            else if (!locked_reg || locked_id_reg != item.track)
            begin
                if (item.score >= cfg.lock_score)
                begin
                    if (confirm_inc >= cfg.confirm_frames)
                    begin
                        locked_next      = 1'b1;
                        locked_id_next   = item.track;
                        mode_next        = MODE_MOVING;
                        miss_next        = 8'd0;
                        confirm_next     = 8'd0;
                        last_motion_next = item.stamp;
                    end
                    else
                    begin
                        confirm_next = confirm_inc;
                    end
                end
                else
                begin
                    confirm_next = 8'd0;
                end
            end
            else
            begin
                miss_next    = 8'd0;
                confirm_next = 8'd0;
                if (score_x5 >= lock_x4)
                begin
                    if (item.fast)
                    begin
                        mode_next        = MODE_MOVING;
                        last_motion_next = item.stamp;
                    end
                    else if (in_hold || suspended)
                    begin
                        mode_next = MODE_STATIC;
                    end
                    else
                    begin
                        mode_next = MODE_GROUND;
                    end
                end
                else
                begin
                    mode_next      = MODE_LOST;
                    locked_next    = 1'b0;
                    locked_id_next = 16'd0;
                end
            end
        end
    end

    assign out_valid_next = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_UNKNOWN;
            locked_reg      <= 1'b0;
            locked_id_reg   <= 16'd0;
            miss_reg        <= 8'd0;
            confirm_reg     <= 8'd0;
            last_motion_reg <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            mode_reg        <= mode_next;
            locked_reg      <= locked_next;
            locked_id_reg   <= locked_id_next;
            miss_reg        <= miss_next;
            confirm_reg     <= confirm_next;
            last_motion_reg <= last_motion_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result beat reflects the state after this report
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            load_state_reg   <= load_code(mode_next);
            is_locked_reg    <= locked_next;
            locked_track_reg <= locked_id_next;
            risk_reg         <= risk_code(mode_next);
            lost_frames_reg  <= miss_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign load_state   = load_state_reg;
    assign is_locked    = is_locked_reg;
    assign locked_track = locked_track_reg;
    assign risk         = risk_reg;
    assign lost_frames  = lost_frames_reg;

    a_unlocked_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !locked_reg |-> locked_id_reg == 16'd0)
        else $error("locked id nonzero without a lock");

    a_locked_mode: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> (mode_reg == MODE_MOVING || mode_reg == MODE_STATIC ||
                        mode_reg == MODE_GROUND))
        else $error("locked track in unknown or lost mode");

    a_lock_clears_counts: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(locked_reg) |-> (confirm_reg == 8'd0 && miss_reg == 8'd0))
        else $error("counters not cleared on lock");

    a_state_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(mode_reg) && $stable(locked_reg) && $stable(miss_reg)))
        else $error("state changed without a report");

endmodule

// ===== hdl/track_lock_state_machine.sv =====
// ----------------------------------------------------------------------------
// track_lock_state_machine: lock state of a suspended-load track
// Takes one tracker report per beat and returns the updated lock state.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one tracker report per beat;
// output channel out_valid/out_ready returns exactly one result beat per
// report, in order. Registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no report is in flight, as the block
// itself has no check for it. A report passes two register stages: the
// input register and the result register. Throughput: one report per
// cycle while the receiver takes results; the lock state is updated
// combinationally between the input register and the result register,
// so the next report sees it with no bubble.
// The velocity squares are formed in front of the input register, so the
// three 16x16 multipliers set the input-side path.
// Reset clears the lock state (mode unknown, no lock, counters zero) and
// loads the register defaults. When the receiver stalls, the result beat
// holds and the input register still takes one report if it is empty;
// after that in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module track_lock_state_machine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [tlsm_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          report_valid,
    input  logic [15:0]                   report_track,
    input  logic [10:0]                   report_score,
    input  logic signed [15:0]            vel_x,
    input  logic signed [15:0]            vel_y,
    input  logic signed [15:0]            vel_z,
    input  logic signed [15:0]            clearance_mm,
    input  logic [31:0]                   stamp_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    load_state,
    output logic                          is_locked,
    output logic [15:0]                   locked_track,
    output logic [1:0]                    risk,
    output logic [7:0]                    lost_frames
);
    import tlsm_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  take;

    tlsm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlsm_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .report_valid (report_valid),
        .report_track (report_track),
        .report_score (report_score),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .clearance_mm (clearance_mm),
        .stamp_ms     (stamp_ms),
        .take         (take),
        .item_valid   (item_valid),
        .item         (item)
    );

    tlsm_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item         (item),
        .take         (take),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .load_state   (load_state),
        .is_locked    (is_locked),
        .locked_track (locked_track),
        .risk         (risk),
        .lost_frames  (lost_frames)
    );

endmodule

// ===== dv/track_lock_state_machine_tb.sv =====
// ----------------------------------------------------------------------------
// track_lock_state_machine_tb: self-checking bench for the track lock FSM
// Drives tracker reports through the valid/ready input channel, predicts each
// result beat with a behavioral lock-state model and compares it field by field.
// A directed table covers thresholds, timeout wrap, loss and relock; random
// phases then run under several register settings with idling on both sides.
// ----------------------------------------------------------------------------
module track_lock_state_machine_tb;

    import tlsm_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 400;
    localparam int NUM_PHASES  = 9;

    typedef struct packed {
        logic               valid;
        logic [15:0]        track;
        logic [10:0]        score;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] clr;
        logic [31:0]        stamp;
    } report_t;

    typedef struct packed {
        logic [2:0]  state;
        logic        locked;
        logic [15:0] track;
        logic [1:0]  risk;
        logic [7:0]  misses;
    } lock_result_t;

    typedef struct packed {
        report_t      stim;
        logic         typed;
        lock_result_t want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                report_valid = 1'b0;
    logic [15:0]         report_track = '0;
    logic [10:0]         report_score = '0;
    logic signed [15:0]  vel_x = '0;
    logic signed [15:0]  vel_y = '0;
    logic signed [15:0]  vel_z = '0;
    logic signed [15:0]  clearance_mm = '0;
    logic [31:0]         stamp_ms = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [2:0]          load_state;
    logic                is_locked;
    logic [15:0]         locked_track;
    logic [1:0]          risk;
    logic [7:0]          lost_frames;

    track_lock_state_machine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .report_valid (report_valid),
        .report_track (report_track),
        .report_score (report_score),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .clearance_mm (clearance_mm),
        .stamp_ms     (stamp_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .load_state   (load_state),
        .is_locked    (is_locked),
        .locked_track (locked_track),
        .risk         (risk),
        .lost_frames  (lost_frames)
    );

    always #2 clk = ~clk;

    // register mirror
    logic [10:0] lock_thr     = LockScoreRst;
    logic [7:0]  confirm_need = ConfirmFramesRst;
    logic [7:0]  miss_limit   = MaxLostFramesRst;
    logic [19:0] hold_ms      = HoldTimeoutRst;
    logic [14:0] float_gap    = FloatingGapRst;

    // tracked lock state
    logic [2:0]  trk_mode      = LOAD_UNKNOWN;
    logic        trk_locked    = 1'b0;
    logic [15:0] trk_id        = '0;
    logic [7:0]  trk_misses    = '0;
    logic [7:0]  trk_confirms  = '0;
    logic [31:0] trk_motion_ms = '0;

    lock_result_t pending_results[$];
    stim_row_t    stim_table[$];

    int          errors = 0;
    int          cycle_count = 0;
    int          inv_burst = 0;
    bit          calm = 1'b0;
    bit          hold_off_req = 1'b0;
    logic [15:0] pool_a = '0;
    logic [15:0] pool_b = '0;
    logic [31:0] stamp_now = '0;

    function automatic void add_row(report_t s, logic typed, lock_result_t want);
        stim_row_t row;
        row.stim  = s;
        row.typed = typed;
        row.want  = want;
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void release_track();
        trk_mode   = LOAD_LOST;
        trk_locked = 1'b0;
        trk_id     = '0;
    endfunction

    function automatic lock_result_t advance_lock_state(report_t r);
        lock_result_t o;
        longint       speed_sq;
        logic [31:0]  elapsed;
        if (!r.valid)
        begin
            if (trk_mode == LOAD_MOVING || trk_mode == LOAD_STATIC)
            begin
                if (trk_misses != 8'hFF)
                    trk_misses++;
                if (trk_misses > miss_limit)
                    release_track();
            end
        end
        else if (!trk_locked || trk_id != r.track)
        begin
            if (r.score >= lock_thr)
            begin
                if (trk_confirms != 8'hFF)
                    trk_confirms++;
                if (trk_confirms >= confirm_need)
                begin
                    trk_locked    = 1'b1;
                    trk_id        = r.track;
                    trk_mode      = LOAD_MOVING;
                    trk_misses    = '0;
                    trk_confirms  = '0;
                    trk_motion_ms = r.stamp;
                end
            end
            else
            begin
                trk_confirms = '0;
            end
        end
        else
        begin
            trk_misses   = '0;
            trk_confirms = '0;
            if (32'(r.score) * 5 >= 32'(lock_thr) * 4)
            begin
                speed_sq = longint'(r.vx) * longint'(r.vx) + longint'(r.vy) * longint'(r.vy)
                         + longint'(r.vz) * longint'(r.vz);
                elapsed = r.stamp - trk_motion_ms;
                if (speed_sq > longint'(SpeedSqLimit))
                begin
                    trk_mode      = LOAD_MOVING;
                    trk_motion_ms = r.stamp;
                end
                else if (elapsed < 32'(hold_ms))
                begin
                    trk_mode = LOAD_STATIC;
                end
                else if (r.clr > $signed({1'b0, float_gap}))
                begin
                    trk_mode = LOAD_STATIC;
                end
                else
                begin
                    trk_mode = LOAD_GROUND;
                end
            end
            else
            begin
                release_track();
            end
        end
        o.state  = trk_mode;
        o.locked = trk_locked;
        o.track  = trk_id;
        o.misses = trk_misses;
        case (trk_mode)
            LOAD_UNKNOWN, LOAD_LOST: o.risk = RISK_UNKNOWN;
            LOAD_STATIC:             o.risk = RISK_IDLE;
            default:                 o.risk = RISK_NORMAL;
        endcase
        return o;
    endfunction

    function automatic report_t rpt(bit v, int trk, int sc, int x, int y, int z, int c,
                                    logic [31:0] st);
        report_t r;
        r.valid = v;
        r.track = 16'(trk);
        r.score = 11'(sc);
        r.vx    = 16'(x);
        r.vy    = 16'(y);
        r.vz    = 16'(z);
        r.clr   = 16'(c);
        r.stamp = st;
        return r;
    endfunction

    function automatic lock_result_t res(int st, bit lk, int id, int rk, int ms);
        lock_result_t o;
        o.state  = 3'(st);
        o.locked = lk;
        o.track  = 16'(id);
        o.risk   = 2'(rk);
        o.misses = 8'(ms);
        return o;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (calm || sel < 70)
            return 0;
        if (sel < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic report_t make_report();
        report_t r;
        int      sel;
        int      b;
        r.valid = 1'b1;
        if (inv_burst > 0)
        begin
            inv_burst--;
            r.valid = 1'b0;
        end
        else if ($urandom_range(0, 99) < 7)
        begin
            r.valid   = 1'b0;
            inv_burst = $urandom_range(0, (miss_limit < 12) ? int'(miss_limit) + 1 : 12);
        end

        sel = $urandom_range(0, 99);
        if (sel < 75)
            r.track = pool_a;
        else if (sel < 90)
            r.track = pool_b;
        else
            r.track = 16'($urandom);

        sel = $urandom_range(0, 99);
        b = (4 * int'(lock_thr)) / 5;
        if (sel < 70)
            r.score = 11'($urandom_range(int'(lock_thr), 2047));
        else if (sel < 85)
            r.score = 11'(b + $urandom_range(0, 2) - 1);  // around the drop bound
        else
            r.score = 11'($urandom);

        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            r.vx = 16'($urandom_range(0, 114) - 57);
            r.vy = 16'($urandom_range(0, 114) - 57);
            r.vz = 16'($urandom_range(0, 114) - 57);
        end
        else if (sel < 60)
        begin
            r.vx = $urandom_range(0, 1) ? 16'sd100 : -16'sd100;
            r.vy = 16'($urandom_range(0, 2) - 1);
            r.vz = '0;
        end
        else
        begin
            r.vx = 16'($urandom);
            r.vy = 16'($urandom);
            r.vz = 16'($urandom);
        end

        if ($urandom_range(0, 99) < 40)
            r.clr = 16'(int'(float_gap) + $urandom_range(0, 2) - 1);
        else
            r.clr = 16'($urandom);

        sel = $urandom_range(0, 99);
        if (sel < 60)
            stamp_now += $urandom_range(0, hold_ms / 2 + 2);
        else if (sel < 92)
            stamp_now += $urandom_range(0, 2 * hold_ms + 10);
        else
            stamp_now = $urandom;
        r.stamp = stamp_now;
        return r;
    endfunction

    task automatic offer_report(report_t r, logic typed, lock_result_t want);
        int           gap;
        lock_result_t predicted;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        report_valid <= r.valid;
        report_track <= r.track;
        report_score <= r.score;
        vel_x        <= r.vx;
        vel_y        <= r.vy;
        vel_z        <= r.vz;
        clearance_mm <= r.clr;
        stamp_ms     <= r.stamp;
        do @(posedge clk); while (!in_ready);
        predicted = advance_lock_state(r);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(logic [2:0] idx, logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_LOCK_SCORE:      lock_thr     = val[10:0];
            CFG_CONFIRM_FRAMES:  confirm_need = val[7:0];
            CFG_LOST_LIMIT:      miss_limit   = val[7:0];
            CFG_HOLD_TIMEOUT_MS: hold_ms      = val[19:0];
            CFG_FLOATING_GAP_MM: float_gap    = val[14:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(int ls, int cf, int ml, int hold, int gap);
        put_reg(CFG_LOCK_SCORE, 20'(ls));
        put_reg(CFG_CONFIRM_FRAMES, 20'(cf));
        put_reg(CFG_LOST_LIMIT, 20'(ml));
        put_reg(CFG_HOLD_TIMEOUT_MS, 20'(hold));
        put_reg(CFG_FLOATING_GAP_MM, 20'(gap));
        cfg_we <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        lock_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, state %0d track %0h",
                         $time, load_state, locked_track);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("load_state", 16'(want.state), 16'(load_state));
                check_field("is_locked", 16'(want.locked), 16'(is_locked));
                check_field("locked_track", want.track, locked_track);
                check_field("risk", 16'(want.risk), 16'(risk));
                check_field("lost_frames", 16'(want.misses), 16'(lost_frames));
            end
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[track_lock_state_machine] ERROR");
            $finish;
        end
    end

    initial
    begin
        report_t r;
        int      n_items;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, register defaults
        add_row(rpt(0, 16'h1234, 0, 0, 0, 0, 0, 0), 1'b1,
                res(LOAD_UNKNOWN, 0, 0, RISK_UNKNOWN, 0));
        add_row(rpt(1, 16'h1234, 717, 0, 0, 0, 0, 1000), 1'b1,
                res(LOAD_UNKNOWN, 0, 0, RISK_UNKNOWN, 0));
        add_row(rpt(1, 16'h1234, 2047, 0, 0, 0, 0, 1000), 1'b1,
                res(LOAD_MOVING, 1, 16'h1234, RISK_NORMAL, 0));
        // score on the drop bound, last ms inside hold
        add_row(rpt(1, 16'h1234, 574, 0, 0, 0, 0, 5999), 1'b0, '0);
        // speed exactly at limit, hold just expired, clearance at gap
        add_row(rpt(1, 16'h1234, 574, 100, 0, 0, 300, 6000), 1'b0, '0);
        // miss while on ground does not count
        add_row(rpt(0, 16'h1234, 0, 0, 0, 0, 0, 6000), 1'b0, '0);
        add_row(rpt(1, 16'h1234, 2047, 0, 0, 0, 301, 6000), 1'b0, '0);
        add_row(rpt(1, 16'h1234, 2047, -32768, -32768, -32768, 0, 32'hFFFF_FFF0),
                1'b0, '0);
        // timestamp wraps
        add_row(rpt(1, 16'h1234, 2047, 0, 0, 0, -32768, 32'h10), 1'b0, '0);
        add_row(rpt(1, 16'h1234, 2047, 0, 0, 0, -32768, 32'h1378), 1'b0, '0);
        // other track while locked
        add_row(rpt(1, 16'hFFFF, 2047, 0, 0, 0, 0, 32'h1400), 1'b0, '0);
        add_row(rpt(1, 16'hFFFF, 0, 0, 0, 0, 0, 32'h1400), 1'b0, '0);
        add_row(rpt(1, 16'h1234, 2047, 32767, 0, 1, 32767, 32'h2000), 1'b0, '0);
        repeat (8)
            add_row(rpt(0, 16'h5A5A, 1024, 1, 1, 1, 1, 32'h2000), 1'b0, '0);
        add_row(rpt(0, 16'h1234, 2047, 0, 0, 0, 0, 32'h2000), 1'b1,
                res(LOAD_LOST, 0, 0, RISK_UNKNOWN, 9));
        add_row(rpt(0, 16'h1234, 2047, 0, 0, 0, 0, 32'h2000), 1'b1,
                res(LOAD_LOST, 0, 0, RISK_UNKNOWN, 9));
        // relock on track 0, then drop on a low score
        add_row(rpt(1, 0, 2047, 0, 0, 0, 0, 32'h3000), 1'b1,
                res(LOAD_LOST, 0, 0, RISK_UNKNOWN, 9));
        add_row(rpt(1, 0, 2047, 0, 0, 0, 0, 32'h3000), 1'b1,
                res(LOAD_MOVING, 1, 0, RISK_NORMAL, 0));
        add_row(rpt(1, 0, 573, 0, 0, 0, 0, 32'h3001), 1'b1,
                res(LOAD_LOST, 0, 0, RISK_UNKNOWN, 0));
        foreach (stim_table[i])
            offer_report(stim_table[i].stim, stim_table[i].typed, stim_table[i].want);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: program_regs(0, 0, 0, 0, 0);
                1: program_regs(2047, 255, 254, 1000000, 32767);
                2: program_regs(LockScoreRst, ConfirmFramesRst, MaxLostFramesRst,
                                HoldTimeoutRst, FloatingGapRst);
                3: program_regs(100, 1, 255, 1000, 300);
                default: program_regs(
                    ($urandom_range(0, 99) < 60) ? $urandom_range(500, 900)
                                                 : $urandom_range(0, 2047),
                    ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                                 : $urandom_range(0, 255),
                    ($urandom_range(0, 99) < 75) ? $urandom_range(0, 10)
                                                 : $urandom_range(0, 255),
                    ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3000)
                                                 : $urandom_range(0, 1048575),
                    ($urandom_range(0, 99) < 50) ? $urandom_range(0, 600)
                                                 : $urandom_range(0, 32767));
            endcase

            case ($urandom_range(0, 3))
                0:       pool_a = '0;
                1:       pool_a = 16'hFFFF;
                default: pool_a = 16'($urandom);
            endcase
            pool_b    = 16'($urandom);
            stamp_now = $urandom_range(0, 1) ? 32'hFFFF_F000 : $urandom;
            inv_burst = 0;
            calm      = (p == 5 || p == 6);
            if (p == 5)
                hold_off_req = 1'b1;  // sender keeps offering, input fills and stalls

            n_items = (p == 0) ? 120 : (p == 1) ? 80 : (p == 2) ? 150 : (p == 3) ? 50 : 130;
            if (p == 3)
            begin
                // lock, then enough misses to saturate the counter
                offer_report(rpt(1, pool_a, 2047, 0, 0, 0, 0, stamp_now), 1'b0, '0);
                repeat (300)
                begin
                    r = make_report();
                    r.valid = 1'b0;
                    offer_report(r, 1'b0, '0);
                end
            end
            repeat (n_items)
                offer_report(make_report(), 1'b0, '0);
            drain();
            calm = 1'b0;
        end

        if (errors == 0)
            $display("[track_lock_state_machine] OK");
        else
            $display("[track_lock_state_machine] ERROR");
        $finish;
    end

endmodule
